### sv/assert_macros.svh
// Assertion macros shared by the tree path query RTL.
// Every macro assumes a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tpq_pkg.sv
// Types and constants of the tree path range query block.
// Used by tpq_slot and tree_path_range_query; depends on nothing.
`timescale 1ns / 1ps

package tpq_pkg;

	localparam logic [2:0] REQ_LOAD   = 3'd0;
	localparam logic [2:0] REQ_PATH_V = 3'd1;
	localparam logic [2:0] REQ_PATH_E = 3'd2;
	localparam logic [2:0] REQ_SUB_V  = 3'd3;
	localparam logic [2:0] REQ_SUB_E  = 3'd4;
	localparam logic [2:0] REQ_LCA    = 3'd5;

	// Results per path query before the climb is cut off.
	localparam int MAX_RES = 22;
	localparam int CNT_W = 5;

	// Values reduced in parallel by the slot unit.
	localparam int SLOT_LANES = 3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [9:0]  vertex_a;
		logic [9:0]  vertex_b;
		logic [9:0]  load_parent;
		logic [9:0]  load_head;
		logic [9:0]  load_pos;
		logic [10:0] load_end;
	} req_t;

	typedef struct packed {
		logic [10:0] range_lo;
		logic [10:0] range_hi;
		logic [9:0]  ancestor;
		logic        empty_res;
		logic        last;
	} res_t;

	// One table entry. The slot fields hold head and parent already reduced to a
	// table index, so the climb never has to reduce a value read from memory.
	typedef struct packed {
		logic [9:0]  parent;
		logic [9:0]  head;
		logic [9:0]  pos;
		logic [10:0] end_pos;
		logic [9:0]  head_slot;
		logic [9:0]  parent_slot;
	} ent_t;

endpackage

### sv/tree_path_range_query.sv
// Top level of the heavy-light decomposition path and subtree query block.
// Depends on tpq_pkg, tpq_slot, tpq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// A request is transferred at a rising edge where start is high and busy is low.
// busy stays high until the request has issued its last result. Each result is
// shown on result for exactly one cycle with result_valid high; the receiver
// must take it then, since nothing here waits for it.
// A load writes one vertex entry and returns no result. A subtree request
// returns one range, an lca request one ancestor, and a path request one range
// per heavy chain crossed (at most 22), with last set on the final one.
// Sequence: every vertex number first passes the slot unit, which makes one
// reduction step per shift of NODES inside the 10-bit vertex range (none when
// NODES >= 1024). A load then writes its entry, a subtree request reads one
// entry for its range. Path and lca requests read both end entries, then per
// chain crossed do one read for the end entries and one for the chain head,
// through registered RAM ports. Each request is done before the next is taken.
// Reset clears the control state only; table entries hold garbage until loaded.
module tree_path_range_query #(
	parameter int NODES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tpq_pkg::req_t request,
	output logic          result_valid,
	output tpq_pkg::res_t result
);

	localparam int AW = $clog2(NODES);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SLOT = 5'b00010,
		S_SUB  = 5'b00100,
		S_CMP  = 5'b01000,
		S_HEAD = 5'b10000
	} state_t;

	state_t state_q, state_d;

	tpq_pkg::req_t req_q;
	logic [9:0]    a_raw_q, b_raw_q, a_slot_q, b_slot_q;
	logic [10:0]   hi_q;
	logic [tpq_pkg::CNT_W-1:0] n_q;
	tpq_pkg::res_t res_q, res_d;
	logic          valid_q, emit;

	logic go, slot_done;
	logic [tpq_pkg::SLOT_LANES-1:0][9:0] slot_in, slot_v;

	logic          we;
	logic [AW-1:0] waddr, raddr0, raddr1;
	tpq_pkg::ent_t wdata, rd0, rd1, ea_w, eb_w;

	logic       swap, same_head, is_edge, is_lca, at_limit;
	logic [9:0] pa_raw, pa_slot, pb_slot;

	assign go = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign result_valid = valid_q;
	assign result = res_q;

	assign slot_in[0] = request.vertex_a;
	assign slot_in[1] = (request.req_type == tpq_pkg::REQ_LOAD) ? request.load_head
		: request.vertex_b;
	assign slot_in[2] = request.load_parent;

	tpq_slot #(.NODES(NODES)) u_slot (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.vin    (slot_in),
		.done   (slot_done),
		.vout   (slot_v)
	);

	tpq_ram #(.WIDTH($bits(tpq_pkg::ent_t)), .DEPTH(NODES)) u_tab (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.rdata0 (rd0),
		.raddr1 (raddr1),
		.rdata1 (rd1)
	);

	// Port 0 carries the entry of end a, port 1 that of end b. The end with the
	// larger position is the one that climbs.
	assign swap = rd0.pos > rd1.pos;
	assign ea_w = swap ? rd1 : rd0;
	assign eb_w = swap ? rd0 : rd1;
	assign pa_raw = swap ? b_raw_q : a_raw_q;
	assign pa_slot = swap ? b_slot_q : a_slot_q;
	assign pb_slot = swap ? a_slot_q : b_slot_q;
	assign same_head = (ea_w.head == eb_w.head);
	assign is_edge = (req_q.req_type == tpq_pkg::REQ_PATH_E);
	assign is_lca = (req_q.req_type == tpq_pkg::REQ_LCA);
	assign at_limit = (n_q == tpq_pkg::CNT_W'(tpq_pkg::MAX_RES - 1));

	assign waddr = AW'(slot_v[0]);
	always_comb begin
		wdata.parent = req_q.load_parent;
		wdata.head = req_q.load_head;
		wdata.pos = req_q.load_pos;
		wdata.end_pos = req_q.load_end;
		wdata.head_slot = slot_v[1];
		wdata.parent_slot = slot_v[2];
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		raddr0 = AW'(a_slot_q);
		raddr1 = AW'(b_slot_q);
		emit = 1'b0;
		res_d = '0;
		case (state_q)
			S_IDLE: begin
				if (go) begin
					state_d = S_SLOT;
				end
			end
			S_SLOT: begin
				raddr0 = AW'(slot_v[0]);
				raddr1 = AW'(slot_v[1]);
				if (slot_done) begin
					case (req_q.req_type)
						tpq_pkg::REQ_LOAD: begin
							we = 1'b1;
							state_d = S_IDLE;
						end
						tpq_pkg::REQ_PATH_V, tpq_pkg::REQ_PATH_E, tpq_pkg::REQ_LCA: begin
							state_d = S_CMP;
						end
						tpq_pkg::REQ_SUB_V, tpq_pkg::REQ_SUB_E: begin
							state_d = S_SUB;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SUB: begin
				emit = 1'b1;
				res_d.range_lo = {1'b0, rd0.pos}
					+ {10'd0, (req_q.req_type == tpq_pkg::REQ_SUB_E)};
				res_d.range_hi = rd0.end_pos;
				res_d.last = 1'b1;
				state_d = S_IDLE;
			end
			S_CMP: begin
				raddr1 = AW'(eb_w.head_slot);
				if (same_head) begin
					emit = 1'b1;
					res_d.last = 1'b1;
					if (is_lca) begin
						res_d.ancestor = pa_raw;
						res_d.empty_res = 1'b1;
					end else if (is_edge && (pa_slot == pb_slot)) begin
						res_d.empty_res = 1'b1;
					end else begin
						res_d.range_lo = {1'b0, ea_w.pos} + {10'd0, is_edge};
						res_d.range_hi = {1'b0, eb_w.pos} + 11'd1;
					end
					state_d = S_IDLE;
				end else if (is_lca && at_limit) begin
					// Runaway climb on inconsistent tables: report where a stands.
					emit = 1'b1;
					res_d.last = 1'b1;
					res_d.ancestor = pa_raw;
					res_d.empty_res = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				// rd1 holds the chain head entry; b moves to the head's parent.
				raddr0 = AW'(a_slot_q);
				raddr1 = AW'(rd1.parent_slot);
				if (is_lca) begin
					state_d = S_CMP;
				end else begin
					emit = 1'b1;
					res_d.range_lo = {1'b0, rd1.pos};
					res_d.range_hi = hi_q;
					res_d.last = at_limit;
					state_d = at_limit ? S_IDLE : S_CMP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		case (state_q)
			S_IDLE: begin
				if (go) begin
					req_q <= request;
					a_raw_q <= request.vertex_a;
					b_raw_q <= request.vertex_b;
				end
			end
			S_SLOT: begin
				a_slot_q <= slot_v[0];
				b_slot_q <= slot_v[1];
				n_q <= '0;
			end
			S_CMP: begin
				a_raw_q <= pa_raw;
				a_slot_q <= pa_slot;
				hi_q <= {1'b0, eb_w.pos} + 11'd1;
			end
			S_HEAD: begin
				b_raw_q <= rd1.parent;
				b_slot_q <= rd1.parent_slot;
				n_q <= n_q + tpq_pkg::CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	`ASSERT_IMPL(a_res_in_request, result_valid, $past(busy), "result outside a request")
	`ASSERT_IMPL(a_last_ends, result_valid, result.last != busy, "last flag does not match end of request")
	`ASSERT_IMPL(a_chain_bound, (state_q == S_CMP) || (state_q == S_HEAD), n_q < tpq_pkg::CNT_W'(tpq_pkg::MAX_RES), "chain count past limit")

endmodule

### sv/tpq_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; holds the per-vertex tables of tree_path_range_query.
`timescale 1ns / 1ps

module tpq_ram #(
	parameter int WIDTH = 61,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

### sv/tpq_slot.sv
// Iterative reduction of vertex numbers modulo the table depth, three lanes.
// Depends on tpq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpq_slot #(
	parameter int NODES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic [tpq_pkg::SLOT_LANES-1:0][9:0]  vin,
	output logic                                 done,
	output logic [tpq_pkg::SLOT_LANES-1:0][9:0]  vout
);

	// Number of restoring steps: one for each shift k with NODES << k still
	// inside the 10-bit vertex range. Zero when every vertex is below NODES.
	function automatic int count_steps();
		int s;
		s = 0;
		for (int k = 0; k < 10; k++) begin
			if ((NODES << k) <= 1023) begin
				s++;
			end
		end
		return s;
	endfunction

	localparam int STEPS = count_steps();

	logic [tpq_pkg::SLOT_LANES-1:0][9:0] r_q;
	logic [3:0]  cnt_q;
	logic        run_q;
	logic [3:0]  kk;
	logic [10:0] sub;

	assign kk = cnt_q - 4'd1;
	assign sub = 11'(NODES) << kk;
	assign done = run_q && (cnt_q == 4'd0);
	assign vout = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 4'd0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 4'(STEPS);
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= kk;
		end
	end

	// Each step leaves every lane below NODES << k.
	always_ff @(posedge clk) begin
		if (go) begin
			r_q <= vin;
		end else if (run_q && (cnt_q != 4'd0)) begin
			for (int i = 0; i < tpq_pkg::SLOT_LANES; i++) begin
				if ({1'b0, r_q[i]} >= sub) begin
					r_q[i] <= r_q[i] - sub[9:0];
				end
			end
		end
	end

	`ASSERT_IMPL(a_slot_range, done, (32'(vout[0]) < NODES) && (32'(vout[1]) < NODES) && (32'(vout[2]) < NODES), "reduced vertex not below table depth")
	`ASSERT_NEXT(a_slot_pulse, done, !done, "slot done held for more than one cycle")
	`ASSERT_IMPL(a_slot_count, run_q, cnt_q <= 4'(STEPS), "slot step counter out of range")

endmodule
